/* design/apic_pkg.sv */
// apic_pkg: shared types, widths and codes for the aromatic pair classifier.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package apic_pkg;

    // Input formats
    localparam int COORD_WIDTH      = 20;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;
    localparam int AXES             = 3;

    // Derived front-end widths
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;                 // B - A per axis
    localparam int DSQ_WIDTH  = 2 * DIFF_WIDTH + 2;              // |v|^2
    localparam int NSQ_WIDTH  = 2 * NORMAL_WIDTH;                // |n|^2
    localparam int DAV_WIDTH  = NORMAL_WIDTH + DIFF_WIDTH + 2;   // n . v
    localparam int DAB_WIDTH  = 2 * NORMAL_WIDTH + 2;            // na . nb

    // Configuration formats
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int DLIM_WIDTH      = 16;
    localparam int DLIM_SQ_WIDTH   = 2 * DLIM_WIDTH;
    localparam int COS_WIDTH       = 15;
    localparam int COS_SQ_WIDTH    = 2 * COS_WIDTH;
    localparam int SCALE_WIDTH     = COS_SQ_WIDTH + NSQ_WIDTH;   // c^2 * |n|^2

    // Wide multiplier
    localparam int MUL_WIDTH  = 64;
    localparam int MUL_HALF   = MUL_WIDTH / 2;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;
    localparam int COS_SHIFT  = 2 * NORMAL_FRAC_BITS;

    // Queue between front and back
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

    // Output formats
    localparam int DIST_OUT_WIDTH = 32;
    localparam int KIND_WIDTH     = 2;

    // Start-to-strobe distance in clock edges
    localparam int LATENCY = 8;

    // Largest squared distance that does not yet count as a ring pair (0.01 A)
    localparam logic [DSQ_WIDTH-1:0] MIN_DIST_SQ = DSQ_WIDTH'(6);

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE            = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FACE_MAX_DIST   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EDGE_MAX_DIST   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CATION_MAX_DIST = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALIGN_COS       = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FACE_COS        = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EDGE_COS        = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CATION_COS      = 3'd7;

    // Mode codes
    localparam logic MODE_RING   = 1'b0;
    localparam logic MODE_CATION = 1'b1;

    // Result kinds
    localparam logic [KIND_WIDTH-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_FACE   = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_EDGE   = 2'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_CATION = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  ring_x;
        logic signed [COORD_WIDTH-1:0]  ring_y;
        logic signed [COORD_WIDTH-1:0]  ring_z;
        logic signed [NORMAL_WIDTH-1:0] ring_nx;
        logic signed [NORMAL_WIDTH-1:0] ring_ny;
        logic signed [NORMAL_WIDTH-1:0] ring_nz;
        logic signed [COORD_WIDTH-1:0]  other_x;
        logic signed [COORD_WIDTH-1:0]  other_y;
        logic signed [COORD_WIDTH-1:0]  other_z;
        logic signed [NORMAL_WIDTH-1:0] other_nx;
        logic signed [NORMAL_WIDTH-1:0] other_ny;
        logic signed [NORMAL_WIDTH-1:0] other_nz;
    } pair_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]     kind;
        logic [DIST_OUT_WIDTH-1:0] dist_sq;
    } result_t;

    typedef struct packed {
        logic                  mode;
        logic [DLIM_WIDTH-1:0] face_max_dist;
        logic [DLIM_WIDTH-1:0] edge_max_dist;
        logic [DLIM_WIDTH-1:0] cation_max_dist;
        logic [COS_WIDTH-1:0]  align_cos;
        logic [COS_WIDTH-1:0]  face_cos;
        logic [COS_WIDTH-1:0]  edge_cos;
        logic [COS_WIDTH-1:0]  cation_cos;
    } cfg_t;

    // Dot products and squared lengths of one pair, front to back
    typedef struct packed {
        logic        [DSQ_WIDTH-1:0] dsq;
        logic        [NSQ_WIDTH-1:0] nasq;
        logic        [NSQ_WIDTH-1:0] nbsq;
        logic signed [DAV_WIDTH-1:0] dav;
        logic signed [DAV_WIDTH-1:0] dbv;
        logic signed [DAB_WIDTH-1:0] dab;
    } vec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    localparam cfg_t CFG_RESET = '{
        mode:            MODE_RING,
        face_max_dist:   16'd1126,
        edge_max_dist:   16'd1408,
        cation_max_dist: 16'd1690,
        align_cos:       15'd12551,
        face_cos:        15'd14189,
        edge_cos:        15'd8192,
        cation_cos:      15'd14189
    };

endpackage

`default_nettype wire

/* design/apic_mul.sv */
// apic_mul: two-stage unsigned 64x64 multiplier built from four 32x32 partials.
// Depends on apic_pkg for widths.
`default_nettype none

module apic_mul (
    input  wire logic                               clk,
    input  wire logic [apic_pkg::MUL_WIDTH-1:0]     a,
    input  wire logic [apic_pkg::MUL_WIDTH-1:0]     b,
    output logic      [apic_pkg::PROD_WIDTH-1:0]    p
);

    localparam int H = apic_pkg::MUL_HALF;
    localparam int W = apic_pkg::MUL_WIDTH;
    localparam int P = apic_pkg::PROD_WIDTH;

    logic [W-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [W-1:0] pp00_next, pp01_next, pp10_next, pp11_next;
    logic [P-1:0] p_reg, p_next;

    always_comb
    begin
        pp00_next = a[H-1:0] * b[H-1:0];
        pp01_next = a[H-1:0] * b[W-1:H];
        pp10_next = a[W-1:H] * b[H-1:0];
        pp11_next = a[W-1:H] * b[W-1:H];
        p_next    = P'(pp00_reg)
                  + (P'(pp01_reg) << H)
                  + (P'(pp10_reg) << H)
                  + {pp11_reg, {W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        pp00_reg <= pp00_next;
        pp01_reg <= pp01_next;
        pp10_reg <= pp10_next;
        pp11_reg <= pp11_next;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* design/apic_front.sv */
// apic_front: takes a pair, forms v = B - A, then per-axis products and sums.
// Depends on apic_pkg; feeds apic_queue.
`default_nettype none

module apic_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire apic_pkg::pair_t pair,
    output logic                 push,
    output apic_pkg::vec_t       entry
);

    localparam int NW = apic_pkg::NORMAL_WIDTH;
    localparam int DW = apic_pkg::DIFF_WIDTH;
    localparam int AX = apic_pkg::AXES;

    // stage 1: difference vector and normals
    logic signed [DW-1:0] v_reg  [AX];
    logic signed [DW-1:0] v_next [AX];
    logic signed [NW-1:0] na_reg [AX];
    logic signed [NW-1:0] na_next[AX];
    logic signed [NW-1:0] nb_reg [AX];
    logic signed [NW-1:0] nb_next[AX];

    // stage 2: per-axis products
    logic        [2*DW-1:0]  vsq_reg [AX];
    logic        [2*DW-1:0]  vsq_next[AX];
    logic        [2*NW-1:0]  nasq_reg [AX];
    logic        [2*NW-1:0]  nasq_next[AX];
    logic        [2*NW-1:0]  nbsq_reg [AX];
    logic        [2*NW-1:0]  nbsq_next[AX];
    logic signed [NW+DW-1:0] av_reg [AX];
    logic signed [NW+DW-1:0] av_next[AX];
    logic signed [NW+DW-1:0] bv_reg [AX];
    logic signed [NW+DW-1:0] bv_next[AX];
    logic signed [2*NW-1:0]  ab_reg [AX];
    logic signed [2*NW-1:0]  ab_next[AX];

    // stage 3: sums
    apic_pkg::vec_t entry_reg, entry_next;

    logic f1_valid_reg, f2_valid_reg, f3_valid_reg;

    always_comb
    begin
        v_next[0]  = DW'(pair.other_x) - DW'(pair.ring_x);
        v_next[1]  = DW'(pair.other_y) - DW'(pair.ring_y);
        v_next[2]  = DW'(pair.other_z) - DW'(pair.ring_z);
        na_next[0] = pair.ring_nx;
        na_next[1] = pair.ring_ny;
        na_next[2] = pair.ring_nz;
        nb_next[0] = pair.other_nx;
        nb_next[1] = pair.other_ny;
        nb_next[2] = pair.other_nz;
    end

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            vsq_next[i]  = v_reg[i] * v_reg[i];
            nasq_next[i] = na_reg[i] * na_reg[i];
            nbsq_next[i] = nb_reg[i] * nb_reg[i];
            av_next[i]   = na_reg[i] * v_reg[i];
            bv_next[i]   = nb_reg[i] * v_reg[i];
            ab_next[i]   = na_reg[i] * nb_reg[i];
        end
    end

    always_comb
    begin
        entry_next.dsq  = apic_pkg::DSQ_WIDTH'(vsq_reg[0]) + apic_pkg::DSQ_WIDTH'(vsq_reg[1])
                        + apic_pkg::DSQ_WIDTH'(vsq_reg[2]);
        entry_next.nasq = nasq_reg[0] + nasq_reg[1] + nasq_reg[2];
        entry_next.nbsq = nbsq_reg[0] + nbsq_reg[1] + nbsq_reg[2];
        entry_next.dav  = apic_pkg::DAV_WIDTH'(av_reg[0]) + apic_pkg::DAV_WIDTH'(av_reg[1])
                        + apic_pkg::DAV_WIDTH'(av_reg[2]);
        entry_next.dbv  = apic_pkg::DAV_WIDTH'(bv_reg[0]) + apic_pkg::DAV_WIDTH'(bv_reg[1])
                        + apic_pkg::DAV_WIDTH'(bv_reg[2]);
        entry_next.dab  = apic_pkg::DAB_WIDTH'(ab_reg[0]) + apic_pkg::DAB_WIDTH'(ab_reg[1])
                        + apic_pkg::DAB_WIDTH'(ab_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AX; i++)
        begin
            v_reg[i]    <= v_next[i];
            na_reg[i]   <= na_next[i];
            nb_reg[i]   <= nb_next[i];
            vsq_reg[i]  <= vsq_next[i];
            nasq_reg[i] <= nasq_next[i];
            nbsq_reg[i] <= nbsq_next[i];
            av_reg[i]   <= av_next[i];
            bv_reg[i]   <= bv_next[i];
            ab_reg[i]   <= ab_next[i];
        end
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    assign push  = f3_valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

/* design/apic_queue.sv */
// apic_queue: short FIFO of dot-product transactions between front and back.
// Depends on apic_pkg for the entry type and depth.
`default_nettype none

module apic_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire apic_pkg::vec_t wdata,
    input  wire logic           pop,
    output apic_pkg::vec_t      rdata,
    output apic_pkg::q_stat_t   stat
);

    localparam int PW = apic_pkg::QUEUE_PTR_WIDTH;
    localparam int D  = apic_pkg::QUEUE_DEPTH;

    apic_pkg::vec_t slot_reg [D];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rdata      = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (PW+1)'(D));

endmodule

`default_nettype wire

/* design/apic_back.sv */
// apic_back: angle tests as squared-cosine compares, classification, output.
// Depends on apic_pkg and apic_mul; drains apic_queue.
`default_nettype none

module apic_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire apic_pkg::cfg_t    cfg,
    input  wire apic_pkg::q_stat_t stat,
    input  wire apic_pkg::vec_t    head,
    output logic                   pop,
    output logic                   done,
    output apic_pkg::result_t      result
);

    localparam int CW  = apic_pkg::COS_WIDTH;
    localparam int C2W = apic_pkg::COS_SQ_WIDTH;
    localparam int L2W = apic_pkg::DLIM_SQ_WIDTH;
    localparam int SW  = apic_pkg::SCALE_WIDTH;
    localparam int DSW = apic_pkg::DSQ_WIDTH;
    localparam int NSW = apic_pkg::NSQ_WIDTH;
    localparam int AVW = apic_pkg::DAV_WIDTH;
    localparam int ABW = apic_pkg::DAB_WIDTH;
    localparam int MW  = apic_pkg::MUL_WIDTH;
    localparam int PW  = apic_pkg::PROD_WIDTH;
    localparam int OW  = apic_pkg::DIST_OUT_WIDTH;

    // squared limits, follow the configuration
    logic [CW-1:0]  ca_sel;
    logic [C2W-1:0] ca2_reg, ca2_next;
    logic [C2W-1:0] al2_reg, al2_next;
    logic [C2W-1:0] fc2_reg, fc2_next;
    logic [C2W-1:0] ec2_reg, ec2_next;
    logic [L2W-1:0] face_d2_reg, face_d2_next;
    logic [L2W-1:0] edge_d2_reg, edge_d2_next;
    logic [L2W-1:0] cat_d2_reg, cat_d2_next;

    // stage s1
    logic           s1_valid_reg;
    logic [SW-1:0]  pa_reg, pa_next;
    logic [SW-1:0]  pb_reg, pb_next;
    logic [SW-1:0]  pf_reg, pf_next;
    logic [SW-1:0]  pe_reg, pe_next;
    logic [AVW-1:0] mav_reg, mav_next;
    logic [AVW-1:0] mbv_reg, mbv_next;
    logic [ABW-1:0] mab_reg, mab_next;
    logic [DSW-1:0] dsq_s1_reg;
    logic [NSW-1:0] nbsq_s1_reg;

    // stages s2, s3 run alongside the wide multipliers
    logic           s2_valid_reg, s3_valid_reg;
    logic [DSW-1:0] dsq_s2_reg, dsq_s3_reg;

    logic [PW-1:0] sq_a, sq_b, sq_ab;
    logic [PW-1:0] rt_a, rt_b, rt_f, rt_e;
    logic [PW-1:0] lf_a, lf_b, lf_ab;

    logic a_off, b_off, face_in, edge_off;
    logic ring_ok, face_near, cat_near;
    logic [apic_pkg::KIND_WIDTH-1:0] kind_next;
    apic_pkg::result_t result_reg, result_next;
    logic done_reg;

    assign pop = !stat.empty;

    always_comb
    begin
        ca_sel       = (cfg.mode == apic_pkg::MODE_CATION) ? cfg.cation_cos : cfg.align_cos;
        ca2_next     = ca_sel * ca_sel;
        al2_next     = cfg.align_cos * cfg.align_cos;
        fc2_next     = cfg.face_cos * cfg.face_cos;
        ec2_next     = cfg.edge_cos * cfg.edge_cos;
        face_d2_next = cfg.face_max_dist * cfg.face_max_dist;
        edge_d2_next = cfg.edge_max_dist * cfg.edge_max_dist;
        cat_d2_next  = cfg.cation_max_dist * cfg.cation_max_dist;
    end

    always_comb
    begin
        pa_next  = ca2_reg * head.nasq;
        pb_next  = al2_reg * head.nbsq;
        pf_next  = fc2_reg * head.nasq;
        pe_next  = ec2_reg * head.nasq;
        mav_next = head.dav[AVW-1] ? AVW'(-head.dav) : AVW'(head.dav);
        mbv_next = head.dbv[AVW-1] ? AVW'(-head.dbv) : AVW'(head.dbv);
        mab_next = head.dab[ABW-1] ? ABW'(-head.dab) : ABW'(head.dab);
    end

    // left sides: dot^2; right sides: c^2 * |p|^2 * |q|^2
    apic_mul u_sq_a  (.clk(clk), .a(MW'(mav_reg)), .b(MW'(mav_reg)), .p(sq_a));
    apic_mul u_sq_b  (.clk(clk), .a(MW'(mbv_reg)), .b(MW'(mbv_reg)), .p(sq_b));
    apic_mul u_sq_ab (.clk(clk), .a(MW'(mab_reg)), .b(MW'(mab_reg)), .p(sq_ab));
    apic_mul u_rt_a  (.clk(clk), .a(MW'(pa_reg)), .b(MW'(dsq_s1_reg)),  .p(rt_a));
    apic_mul u_rt_b  (.clk(clk), .a(MW'(pb_reg)), .b(MW'(dsq_s1_reg)),  .p(rt_b));
    apic_mul u_rt_f  (.clk(clk), .a(MW'(pf_reg)), .b(MW'(nbsq_s1_reg)), .p(rt_f));
    apic_mul u_rt_e  (.clk(clk), .a(MW'(pe_reg)), .b(MW'(nbsq_s1_reg)), .p(rt_e));

    always_comb
    begin
        lf_a  = sq_a  << apic_pkg::COS_SHIFT;
        lf_b  = sq_b  << apic_pkg::COS_SHIFT;
        lf_ab = sq_ab << apic_pkg::COS_SHIFT;

        // "more than the angle off" is a strict less-than on the left side
        a_off    = lf_a < rt_a;
        b_off    = lf_b < rt_b;
        face_in  = lf_ab > rt_f;
        edge_off = lf_ab < rt_e;

        ring_ok   = (dsq_s3_reg > apic_pkg::MIN_DIST_SQ)
                 && (dsq_s3_reg <= DSW'(edge_d2_reg))
                 && !(a_off && b_off);
        face_near = dsq_s3_reg < DSW'(face_d2_reg);
        cat_near  = dsq_s3_reg <= DSW'(cat_d2_reg);

        kind_next = apic_pkg::KIND_NONE;
        if (cfg.mode == apic_pkg::MODE_CATION)
        begin
            if (cat_near && !a_off)
            begin
                kind_next = apic_pkg::KIND_CATION;
            end
        end
        else if (ring_ok)
        begin
            if (face_in && face_near)
            begin
                kind_next = apic_pkg::KIND_FACE;
            end
            else if (edge_off)
            begin
                kind_next = apic_pkg::KIND_EDGE;
            end
        end

        result_next.kind    = kind_next;
        result_next.dist_sq = (|dsq_s3_reg[DSW-1:OW]) ? {OW{1'b1}} : dsq_s3_reg[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        ca2_reg     <= ca2_next;
        al2_reg     <= al2_next;
        fc2_reg     <= fc2_next;
        ec2_reg     <= ec2_next;
        face_d2_reg <= face_d2_next;
        edge_d2_reg <= edge_d2_next;
        cat_d2_reg  <= cat_d2_next;

        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        pf_reg      <= pf_next;
        pe_reg      <= pe_next;
        mav_reg     <= mav_next;
        mbv_reg     <= mbv_next;
        mab_reg     <= mab_next;
        dsq_s1_reg  <= head.dsq;
        nbsq_s1_reg <= head.nbsq;
        dsq_s2_reg  <= dsq_s1_reg;
        dsq_s3_reg  <= dsq_s2_reg;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* design/aromatic_pair_interaction_classifier.sv */
// Aromatic pair classifier top level: configuration registers, front, queue, back.
// Depends on apic_pkg, apic_front, apic_queue, apic_back (and apic_mul below it).
// Pipeline: a transaction taken at a clock edge passes through 3 front stages, 1 queue slot
//   and 4 back stages (s1, s2, s3 and the done/result register) before done is raised.
// Throughput: one transaction per cycle; the back end drains one queue entry per cycle,
//   so the queue holds at most one entry and busy stays low.
// Reset: rst_n clears the pipeline valids, queue pointers and the configuration
//   registers (to their documented defaults); no clearing pass is needed.
`default_nettype none

module aromatic_pair_interaction_classifier (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire apic_pkg::pair_t                        pair,
    output logic                                        done,
    output apic_pkg::result_t                           result,
    input  wire logic                                   cfg_write,
    input  wire logic [apic_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [apic_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    // Configuration registers. The user must make writes only while the block is idle; the block
    // itself does not enforce this. The pipeline reads them directly without shadow copies.
    apic_pkg::cfg_t cfg_reg, cfg_next;

    // Front to queue
    logic           front_push;
    apic_pkg::vec_t front_entry;

    // Queue to back
    apic_pkg::vec_t    q_head;
    apic_pkg::q_stat_t q_stat;
    logic              back_pop;

    logic accept;

    // A transaction is taken whenever start is seen while the queue has room.
    assign busy   = q_stat.full;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                apic_pkg::CFG_MODE:
                    cfg_next.mode = cfg_data[0];
                apic_pkg::CFG_FACE_MAX_DIST:
                    cfg_next.face_max_dist = cfg_data;
                apic_pkg::CFG_EDGE_MAX_DIST:
                    cfg_next.edge_max_dist = cfg_data;
                apic_pkg::CFG_CATION_MAX_DIST:
                    cfg_next.cation_max_dist = cfg_data;
                apic_pkg::CFG_ALIGN_COS:
                    cfg_next.align_cos = cfg_data[apic_pkg::COS_WIDTH-1:0];
                apic_pkg::CFG_FACE_COS:
                    cfg_next.face_cos = cfg_data[apic_pkg::COS_WIDTH-1:0];
                apic_pkg::CFG_EDGE_COS:
                    cfg_next.edge_cos = cfg_data[apic_pkg::COS_WIDTH-1:0];
                apic_pkg::CFG_CATION_COS:
                    cfg_next.cation_cos = cfg_data[apic_pkg::COS_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= apic_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: difference vector, per-axis products, sums of squares and dots.
    apic_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .pair  (pair),
        .push  (front_push),
        .entry (front_entry)
    );

    // Queue decouples the two halves.
    apic_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_entry),
        .pop   (back_pop),
        .rdata (q_head),
        .stat  (q_stat)
    );

    // Back: exact squared-cosine compares and the kind decision.
    apic_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .stat  (q_stat),
        .head  (q_head),
        .pop   (back_pop),
        .done  (done),
        .result(result)
    );

endmodule

`default_nettype wire

/* design/apic_checker.sv */
// apic_checker: port-level properties of the classifier, bound to the top level.
// Depends on apic_pkg and aromatic_pair_interaction_classifier.
`default_nettype none

module apic_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire apic_pkg::result_t result
);

    // every transaction produces a strobe a fixed distance later
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(apic_pkg::LATENCY) done)
        else $error("missing result strobe");

    // no strobe without a transaction at the matching edge
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, apic_pkg::LATENCY))
        else $error("unexpected result strobe");

    // ring kinds require a separation above the minimum distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.kind == apic_pkg::KIND_FACE || result.kind == apic_pkg::KIND_EDGE))
        |-> (result.dist_sq > apic_pkg::DIST_OUT_WIDTH'(apic_pkg::MIN_DIST_SQ)))
        else $error("ring kind below minimum distance");

    // face-to-face lies under a 16-bit limit, never at saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == apic_pkg::KIND_FACE) |-> (result.dist_sq != '1))
        else $error("face-to-face with saturated distance");

endmodule

bind aromatic_pair_interaction_classifier apic_checker u_apic_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for aromatic_pair_interaction_classifier.
// Depends on apic_pkg and the classifier RTL; expected results come from an in-bench predictor.

module tb_top;
    import apic_pkg::*;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  PHASE_ITEMS = 200;
    localparam int  NORM_ONE    = 1 << NORMAL_FRAC_BITS;
    localparam real PI          = 3.14159265358979;

    // integer 3-vector used only for building stimulus geometry
    typedef struct packed {
        int x;
        int y;
        int z;
    } ivec_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       start     = 1'b0;
    logic                       busy;
    pair_t                      pair      = '0;
    logic                       done;
    result_t                    result;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    cfg_t    cfg_model = CFG_RESET;  // register image as the block should hold it
    pair_t   pair_queue[$];          // pairs waiting for the driver
    result_t expected_results[$];    // one entry per accepted transaction, oldest first
    int      idle_pct       = 0;     // sender idle probability, percent
    int      mismatch_count = 0;
    int      cycle_count    = 0;

    aromatic_pair_interaction_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pair      (pair),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint unsigned magnitude(longint signed x);
        return (x < 0) ? -x : x;
    endfunction

    // Compares an angle against acos(c) without division or roots:
    //   dot^2 * 2^(2F)  vs  c^2 * |p|^2 * |q|^2
    // -1: angle wider than the limit, +1: narrower, 0: exact tie.
    // Left side peaks near 2^102, so 128 bits carry everything exactly.
    function automatic int angle_cmp(longint unsigned dot_mag, longint unsigned p_sq,
                                     longint unsigned q_sq, logic [COS_WIDTH-1:0] c);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [63:0]  scale;
        lhs   = {64'd0, dot_mag} * {64'd0, dot_mag};
        lhs   = lhs << (2 * NORMAL_FRAC_BITS);
        scale = 64'(c) * 64'(c) * p_sq;   // below 2^62 even for a 15-bit cosine
        rhs   = {64'd0, scale} * {64'd0, q_sq};
        if (lhs < rhs)
            return -1;
        if (rhs < lhs)
            return 1;
        return 0;
    endfunction

    // Classification of one pair under the current register image.
    function automatic result_t classify_pair(pair_t p);
        longint signed   v[3];
        longint signed   na[3];
        longint signed   nb[3];
        longint unsigned dsq;
        longint unsigned nasq;
        longint unsigned nbsq;
        longint signed   dav;
        longint signed   dbv;
        longint signed   dab;
        logic            keep;
        result_t         r;
        int              i;
        v[0]  = longint'($signed(p.other_x)) - longint'($signed(p.ring_x));
        v[1]  = longint'($signed(p.other_y)) - longint'($signed(p.ring_y));
        v[2]  = longint'($signed(p.other_z)) - longint'($signed(p.ring_z));
        na[0] = longint'($signed(p.ring_nx));
        na[1] = longint'($signed(p.ring_ny));
        na[2] = longint'($signed(p.ring_nz));
        nb[0] = longint'($signed(p.other_nx));
        nb[1] = longint'($signed(p.other_ny));
        nb[2] = longint'($signed(p.other_nz));
        dsq  = 0;
        nasq = 0;
        nbsq = 0;
        dav  = 0;
        dbv  = 0;
        dab  = 0;
        for (i = 0; i < 3; i++)
        begin
            dsq  += v[i] * v[i];
            nasq += na[i] * na[i];
            nbsq += nb[i] * nb[i];
            dav  += na[i] * v[i];
            dbv  += nb[i] * v[i];
            dab  += na[i] * nb[i];
        end

        r.kind = KIND_NONE;
        if (cfg_model.mode == MODE_RING)
        begin
            // overall window: not coincident, not beyond the edge limit
            keep = (dsq > 64'(MIN_DIST_SQ)) &&
                   (dsq <= 64'(cfg_model.edge_max_dist) * 64'(cfg_model.edge_max_dist));
            // v must be near at least one of the two normals
            if (keep && angle_cmp(magnitude(dbv), nbsq, dsq, cfg_model.align_cos) < 0 &&
                angle_cmp(magnitude(dav), nasq, dsq, cfg_model.align_cos) < 0)
                keep = 1'b0;
            if (keep)
            begin
                if (angle_cmp(magnitude(dab), nasq, nbsq, cfg_model.face_cos) > 0 &&
                    dsq < 64'(cfg_model.face_max_dist) * 64'(cfg_model.face_max_dist))
                    r.kind = KIND_FACE;
                else if (angle_cmp(magnitude(dab), nasq, nbsq, cfg_model.edge_cos) < 0)
                    r.kind = KIND_EDGE;
            end
        end
        else if (dsq <= 64'(cfg_model.cation_max_dist) * 64'(cfg_model.cation_max_dist) &&
                 angle_cmp(magnitude(dav), nasq, dsq, cfg_model.cation_cos) >= 0)
            r.kind = KIND_CATION;   // a tie (zero v or zero normal) still counts

        r.dist_sq = (dsq > 64'hFFFF_FFFF) ? '1 : dsq[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic real rand_real(real lo, real hi);
        return lo + (hi - lo) * ($urandom_range(0, 1000000) / 1000000.0);
    endfunction

    // rescale a nonzero real vector to the given length, rounded
    function automatic ivec_t scaled(real x, real y, real z, real len_out);
        real   len;
        ivec_t r;
        len = $sqrt(x * x + y * y + z * z);
        r.x = $rtoi(x * len_out / len + ((x >= 0.0) ? 0.5 : -0.5));
        r.y = $rtoi(y * len_out / len + ((y >= 0.0) ? 0.5 : -0.5));
        r.z = $rtoi(z * len_out / len + ((z >= 0.0) ? 0.5 : -0.5));
        return r;
    endfunction

    // uniform direction: rejection sampling inside the unit ball
    function automatic ivec_t rand_dir();
        real x;
        real y;
        real z;
        do
        begin
            x = rand_real(-1.0, 1.0);
            y = rand_real(-1.0, 1.0);
            z = rand_real(-1.0, 1.0);
        end
        while (x * x + y * y + z * z < 0.01 || x * x + y * y + z * z > 1.0);
        return scaled(x, y, z, NORM_ONE);
    endfunction

    // unit vector at the given angle from a, in a random plane through a
    function automatic ivec_t tilt(ivec_t a, real deg);
        ivec_t r;
        real   px;
        real   py;
        real   pz;
        real   plen;
        real   alen;
        real   t;
        alen = $sqrt(real'(a.x) * a.x + real'(a.y) * a.y + real'(a.z) * a.z);
        do
        begin
            r    = rand_dir();
            px   = real'(a.y) * r.z - real'(a.z) * r.y;
            py   = real'(a.z) * r.x - real'(a.x) * r.z;
            pz   = real'(a.x) * r.y - real'(a.y) * r.x;
            plen = $sqrt(px * px + py * py + pz * pz);
        end
        while (plen < 1.0e7);
        t = deg * PI / 180.0;
        return scaled(a.x / alen * $cos(t) + px / plen * $sin(t),
                      a.y / alen * $cos(t) + py / plen * $sin(t),
                      a.z / alen * $cos(t) + pz / plen * $sin(t), NORM_ONE);
    endfunction

    // every field random over its full width
    function automatic pair_t noise_pair();
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(pair_t)-1:0];
    endfunction

    // Realistic pair: unit normals at chosen relative angles, separation
    // pointed near one of the normals and mostly within a few angstrom,
    // so that every classification branch is reached often.
    function automatic pair_t shaped_pair();
        ivec_t na;
        ivec_t nb;
        ivec_t dir;
        ivec_t v;
        int    span;
        int    rx;
        int    ry;
        int    rz;
        real   s;
        pair_t p;
        na = rand_dir();
        case ($urandom_range(0, 3))
            0:       nb = tilt(na, rand_real(0.0, 35.0));   // stacked
            1:       nb = tilt(na, rand_real(55.0, 90.0));  // T-shaped
            2:       nb = tilt(na, rand_real(0.0, 90.0));
            default: nb = rand_dir();
        endcase
        if ($urandom_range(0, 1))
        begin
            nb.x = -nb.x;
            nb.y = -nb.y;
            nb.z = -nb.z;
        end
        case ($urandom_range(0, 4))
            0, 1:    dir = tilt(na, rand_real(0.0, 50.0));
            2:       dir = tilt(nb, rand_real(0.0, 50.0));
            3:       dir = rand_dir();
            default: dir = tilt(na, rand_real(25.0, 45.0)); // around the angle limits
        endcase
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30000) : $urandom_range(0, 1900);
        if ($urandom_range(0, 1))
            span = -span;
        v.x = $rtoi(real'(dir.x) * span / NORM_ONE);
        v.y = $rtoi(real'(dir.y) * span / NORM_ONE);
        v.z = $rtoi(real'(dir.z) * span / NORM_ONE);
        if ($urandom_range(0, 9) == 0)
        begin
            // near-coincident centers around the minimum distance
            v.x = int'($urandom_range(0, 6)) - 3;
            v.y = int'($urandom_range(0, 6)) - 3;
            v.z = int'($urandom_range(0, 6)) - 3;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            // normal that is not unit length
            s    = rand_real(0.0, 1.99);
            na.x = $rtoi(na.x * s);
            na.y = $rtoi(na.y * s);
            na.z = $rtoi(na.z * s);
        end
        rx = int'($urandom_range(0, 1000000)) - 500000;
        ry = int'($urandom_range(0, 1000000)) - 500000;
        rz = int'($urandom_range(0, 1000000)) - 500000;
        p.ring_x   = COORD_WIDTH'(rx);
        p.ring_y   = COORD_WIDTH'(ry);
        p.ring_z   = COORD_WIDTH'(rz);
        p.ring_nx  = NORMAL_WIDTH'(na.x);
        p.ring_ny  = NORMAL_WIDTH'(na.y);
        p.ring_nz  = NORMAL_WIDTH'(na.z);
        p.other_x  = COORD_WIDTH'(rx + v.x);
        p.other_y  = COORD_WIDTH'(ry + v.y);
        p.other_z  = COORD_WIDTH'(rz + v.z);
        p.other_nx = NORMAL_WIDTH'(nb.x);
        p.other_ny = NORMAL_WIDTH'(nb.y);
        p.other_nz = NORMAL_WIDTH'(nb.z);
        return p;
    endfunction

    // directed pair from explicit numbers: A center, A normal, B point, B normal
    function automatic pair_t mk(int ax, int ay, int az, int anx, int any, int anz,
                                 int bx, int by, int bz, int bnx, int bny, int bnz);
        pair_t p;
        p.ring_x   = COORD_WIDTH'(ax);
        p.ring_y   = COORD_WIDTH'(ay);
        p.ring_z   = COORD_WIDTH'(az);
        p.ring_nx  = NORMAL_WIDTH'(anx);
        p.ring_ny  = NORMAL_WIDTH'(any);
        p.ring_nz  = NORMAL_WIDTH'(anz);
        p.other_x  = COORD_WIDTH'(bx);
        p.other_y  = COORD_WIDTH'(by);
        p.other_z  = COORD_WIDTH'(bz);
        p.other_nx = NORMAL_WIDTH'(bnx);
        p.other_ny = NORMAL_WIDTH'(bny);
        p.other_nz = NORMAL_WIDTH'(bnz);
        return p;
    endfunction

    // appends one pair to the driver's backlog
    function automatic void add_pair(pair_t p);
        pair_queue.insert(pair_queue.size(), p);
    endfunction

    // ------------------------------------------------------------------
    // Configuration and sequencing
    // ------------------------------------------------------------------

    // One register write per clock; the register image follows at once,
    // which is safe because writes only happen with the pipeline empty.
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MODE:            cfg_model.mode            = val[0];
            CFG_FACE_MAX_DIST:   cfg_model.face_max_dist   = val[DLIM_WIDTH-1:0];
            CFG_EDGE_MAX_DIST:   cfg_model.edge_max_dist   = val[DLIM_WIDTH-1:0];
            CFG_CATION_MAX_DIST: cfg_model.cation_max_dist = val[DLIM_WIDTH-1:0];
            CFG_ALIGN_COS:       cfg_model.align_cos       = val[COS_WIDTH-1:0];
            CFG_FACE_COS:        cfg_model.face_cos        = val[COS_WIDTH-1:0];
            CFG_EDGE_COS:        cfg_model.edge_cos        = val[COS_WIDTH-1:0];
            CFG_CATION_COS:      cfg_model.cation_cos      = val[COS_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic m, logic [15:0] fd, logic [15:0] ed, logic [15:0] cd,
                             logic [15:0] ac, logic [15:0] fc, logic [15:0] ec,
                             logic [15:0] cc);
        write_reg(CFG_MODE, {15'd0, m});
        write_reg(CFG_FACE_MAX_DIST, fd);
        write_reg(CFG_EDGE_MAX_DIST, ed);
        write_reg(CFG_CATION_MAX_DIST, cd);
        write_reg(CFG_ALIGN_COS, ac);
        write_reg(CFG_FACE_COS, fc);
        write_reg(CFG_EDGE_COS, ec);
        write_reg(CFG_CATION_COS, cc);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Polled on the falling edge so the driver and monitor have settled.
    // Every transaction yields a result, so an empty store means an empty pipe.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pair_queue.size() != 0 || start || expected_results.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic run_phase(int items, int idle);
        int k;
        @(negedge clk);
        idle_pct = idle;
        for (k = 0; k < items; k++)
            add_pair(($urandom_range(0, 9) < 7) ? shaped_pair() : noise_pair());
        wait_idle();
    endtask

    task automatic flag_mismatch(string msg);
        if (mismatch_count < 100)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued pairs, holds start while busy, records the
    // expected result at the edge where the transaction is taken.
    // Idle cycles carry random pair data that the block must ignore.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                expected_results.insert(expected_results.size(), classify_pair(pair));
            if (!start || !busy)
            begin
                if (pair_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    pair  <= pair_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    pair  <= noise_pair();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobe is one result, matched against the oldest
    // expectation field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                flag_mismatch($sformatf("result with nothing expected: kind=%0d dist_sq=%0h",
                                        result.kind, result.dist_sq));
            else
            begin
                want = expected_results.pop_front();
                if (result.kind !== want.kind)
                    flag_mismatch($sformatf("kind got %0d want %0d", result.kind, want.kind));
                if (result.dist_sq !== want.dist_sq)
                    flag_mismatch($sformatf("dist_sq got %0h want %0h",
                                            result.dist_sq, want.dist_sq));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ring-ring cases at the power-on settings
        // (face 4.4 A / 30 deg, edge 5.5 A / 60 deg, alignment 40 deg).
        idle_pct = 0;
        add_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // opposite corners of the coordinate range: squared distance saturates
        add_pair(mk(-524288, -524288, -524288, 32767, 32767, 32767,
                    524287, 524287, 524287, -32768, -32768, -32768));
        add_pair(mk(524287, 524287, 524287, -32768, -32768, -32768,
                    -524288, -524288, -524288, 32767, 32767, 32767));
        // just at the minimum distance, then just past it
        add_pair(mk(0, 0, 0, 0, 0, 16384, 2, 1, 1, 0, 0, 16384));
        add_pair(mk(0, 0, 0, 11585, 11585, 0, 2, 2, 0, 11585, 11585, 0));
        // stacked rings, inside and at the face distance limit
        add_pair(mk(1000, -2000, 300, 0, 0, 16384, 1000, -2000, 1200, 0, 0, 16384));
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 1125, 0, 0, 16384));
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 1126, 0, 0, 16384));
        // antiparallel normals still count as stacked
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, -800, 0, 0, -16384));
        // T-shape at and past the edge distance limit
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 1408, 16384, 0, 0));
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 1409, 16384, 0, 0));
        // separation aligned only with the second normal
        add_pair(mk(0, 0, 0, 0, 0, 16384, 1200, 0, 0, 16384, 0, 0));
        // side by side: off both normals
        add_pair(mk(0, 0, 0, 0, 0, 16384, 900, 0, 0, 0, 0, 16384));
        // normals 45 deg apart: neither stacked nor T-shaped
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 900, 0, 11585, 11585));
        // zero normals make every angle test a tie
        add_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 500, 0, 0, 0));
        // normals that are not unit length
        add_pair(mk(0, 0, 0, 0, 0, 32767, 0, 0, 1000, 0, 0, 8192));
        add_pair(mk(5, 5, 5, -32768, -32768, -32768, 205, 205, 205,
                    -32768, -32768, -32768));
        wait_idle();

        // Directed ring-cation cases (6.6 A, 30 deg)
        write_all(MODE_CATION, 16'd1126, 16'd1408, 16'd1690, 16'd12551, 16'd14189,
                  16'd8192, 16'd14189);
        @(negedge clk);
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 1690, 0, 0, 0));
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, 1691, 0, 0, 0));
        add_pair(mk(7, 7, 7, 0, 0, 16384, 7, 7, 7, 0, 0, 0));       // cation on center
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 0, -1000, 0, 0, 0));   // below the ring
        add_pair(mk(0, 0, 0, 0, 0, 16384, 1000, 0, 0, 0, 0, 0));    // in the ring plane
        add_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 500, 0, 0, 0));         // zero normal
        add_pair(mk(0, 0, 0, 0, 0, 16384, 0, 300, 1000, -32768, 32767, 12345));
        wait_idle();

        // Random phases over a range of settings and sender idling
        write_all(MODE_RING, 16'd1126, 16'd1408, 16'd1690, 16'd12551, 16'd14189,
                  16'd8192, 16'd14189);
        run_phase(PHASE_ITEMS, 0);

        write_all(MODE_CATION, 16'd1126, 16'd1408, 16'd1690, 16'd12551, 16'd14189,
                  16'd8192, 16'd14189);
        run_phase(PHASE_ITEMS, 75);

        // widest limits, zero cosines: alignment never rejects, any tilt short of 90 deg is stacked
        write_all(MODE_RING, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(PHASE_ITEMS, 20);

        // cosine registers at and beyond one but a zero cation cosine, zero face and edge distances
        write_all(MODE_CATION, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16384, 16'd0);
        run_phase(PHASE_ITEMS, 0);

        write_all(MODE_RING, 16'd0, 16'hFFFF, 16'd0, 16'd16384, 16'd16384, 16'hFFFF,
                  16'd16384);
        run_phase(PHASE_ITEMS, 75);

        write_all(MODE_RING, 16'($urandom_range(300, 2000)), 16'($urandom_range(300, 2000)),
                  16'($urandom_range(300, 2000)), 16'($urandom_range(0, 16384)),
                  16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                  16'($urandom_range(0, 16384)));
        run_phase(PHASE_ITEMS, 20);

        write_all(MODE_CATION, 16'($urandom_range(300, 2000)), 16'($urandom_range(300, 2000)),
                  16'($urandom_range(300, 2000)), 16'($urandom_range(0, 16384)),
                  16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                  16'($urandom_range(0, 16384)));
        run_phase(PHASE_ITEMS, 0);

        // let any stray strobe show up before judging
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
